// ===== hw/rtl/gdbs_pkg.sv =====
// Shared types, constants and fixed-point helpers of the blended setpoint block.
package gdbs_pkg;

  localparam logic [2:0] OP_EXPERT_POS  = 3'd0;
  localparam logic [2:0] OP_LEARNER_POS = 3'd1;
  localparam logic [2:0] OP_EXPERT_BTN  = 3'd2;
  localparam logic [2:0] OP_LEARNER_BTN = 3'd3;
  localparam logic [2:0] OP_TICK        = 3'd4;

  localparam logic [1:0] CMD_MOVE      = 2'd0;
  localparam logic [1:0] CMD_STOP_IDLE = 2'd1;
  localparam logic [1:0] CMD_STOP_WS   = 2'd2;

  localparam logic [1:0] CFG_ALPHA      = 2'd0;
  localparam logic [1:0] CFG_MAN_ENABLE = 2'd1;
  localparam logic [1:0] CFG_MAN_SCALE  = 2'd2;

  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [16:0] ALPHA_RESET   = 17'd52429;
  localparam logic [16:0] MAN_RESET     = 17'd6554;
  localparam logic [16:0] RAMP_MIN      = 17'd6554;
  localparam logic signed [17:0] FILT_OLD  = 18'sd55706;
  localparam logic signed [17:0] FILT_NEW  = 18'sd9830;
  localparam logic signed [17:0] RAMP_GAIN = 18'sd58982;
  // floor(RAMP_GAIN * 2^19 / H_SPAN); the ramp quotient estimate is taken 19 bits down.
  localparam logic signed [17:0] RAMP_RECIP = 18'sd94522;
  localparam logic [18:0] H_SPAN        = 19'd327155;
  localparam logic signed [32:0] H_SPAN_NEG = -33'sd327155;
  localparam logic signed [31:0] H_HIGH = 32'sd661022;
  localparam logic signed [31:0] H_LOW  = 32'sd333867;
  localparam logic signed [31:0] WS_X_MIN = -32'sd6375342;
  localparam logic signed [31:0] WS_X_MAX = 32'sd1677722;
  localparam logic signed [31:0] WS_Y_MIN = -32'sd5872026;
  localparam logic signed [31:0] WS_Y_MAX = 32'sd5872026;
  localparam logic signed [31:0] WS_Z_MIN = -32'sd335544;
  localparam logic signed [31:0] WS_Z_MAX = 32'sd6375342;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

  // Round to nearest at 16 fractional bits, ties toward positive infinity.
  function automatic logic signed [35:0] rnd_q16(input logic signed [51:0] v);
    logic signed [51:0] w;
    w = v + 52'sd32768;
    return w[51:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [16:0] clamp_q16(input logic [16:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

// ===== hw/rtl/gdbs_ifs.sv =====
// Handshake interfaces for the event, result and register-write channels.
interface gdbs_in_if;
  logic valid;
  logic ready;
  logic [2:0] operation;
  logic signed [31:0] hand_x;
  logic signed [31:0] hand_y;
  logic signed [31:0] hand_z;
  logic pressed;
  logic tool_valid;
  logic signed [31:0] tool_x;
  logic signed [31:0] tool_y;
  logic signed [31:0] tool_z;
  logic signed [31:0] tool_rx;
  logic signed [31:0] tool_ry;
  logic signed [31:0] tool_rz;
  modport source (output valid, operation, hand_x, hand_y, hand_z, pressed, tool_valid,
                  tool_x, tool_y, tool_z, tool_rx, tool_ry, tool_rz, input ready);
  modport sink (input valid, operation, hand_x, hand_y, hand_z, pressed, tool_valid,
                tool_x, tool_y, tool_z, tool_rx, tool_ry, tool_rz, output ready);
endinterface

interface gdbs_out_if;
  logic valid;
  logic ready;
  logic [1:0] command;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic signed [31:0] target_rx;
  logic signed [31:0] target_ry;
  logic signed [31:0] target_rz;
  logic [16:0] scale_applied;
  modport source (output valid, command, target_x, target_y, target_z, target_rx,
                  target_ry, target_rz, scale_applied, input ready);
  modport sink (input valid, command, target_x, target_y, target_z, target_rx,
                target_ry, target_rz, scale_applied, output ready);
endinterface

interface gdbs_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/gdbs_mac.sv =====
// Shared multiply-accumulate unit used by every multiplying step of the sequencer.
module gdbs_mac (
  input  logic                   clk,
  input  gdbs_pkg::mac_ctl_t     ctl,
  input  logic signed [32:0]     op_a,
  input  logic signed [17:0]     op_b,
  output logic signed [51:0]     acc
);

  logic signed [51:0] acc_r;
  logic signed [50:0] prod;

  assign prod = op_a * op_b;
  assign acc = acc_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= (ctl.clr ? 52'sd0 : acc_r) + 52'(prod);
    end
  end

endmodule

// ===== hw/rtl/gated_dual_blend_setpoint.sv =====
// Top level of the gated dual-arm blended setpoint generator.
//
// Events enter on in_ch (valid/ready); one transaction is one event: a hand
// position, a button, or a control tick with the measured tool pose. Results
// leave on out_ch; only ticks produce one. Register writes use cfg_ch, which
// is always ready and should be used only while the block is idle.
// All multiplications run through one shared multiply-accumulate unit under a
// sequencer, so in_ch.ready is low while an event is being worked on.
// Button and unknown events and the first position after a release are
// handled in the idle state; later positions run three axes of two products
// and a writeback. A tick with one or both arms held accumulates the held
// arms and blends the axes; when the scale is neither manual nor pinned at an
// end of the height ramp, it first takes a reciprocal multiply and one correction.
// A stop with nobody holding goes straight to the emit step; a tick with nobody
// holding and nothing moving returns to idle.
// The result sits in an output register; the next event is accepted while
// it waits. A tick that finishes while the receiver stalls holds in its
// emit step until the register frees up.
// Reset is synchronous; the arm and register state clears at once, no clearing pass.
module gated_dual_blend_setpoint (
  input  logic             clk,
  input  logic             rst_n,
  gdbs_in_if.sink          in_ch,
  gdbs_out_if.source       out_ch,
  gdbs_cfg_if.sink         cfg_ch
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FILT  = 9'b000000010,
    S_TICK  = 9'b000000100,
    S_RMUL  = 9'b000001000,
    S_RDIV  = 9'b000010000,
    S_ACC   = 9'b000100000,
    S_BLEND = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state_r;

  logic signed [31:0] filt_r [2][3];
  logic signed [31:0] anch_r [2][3];
  logic signed [31:0] sum_r  [2][3];
  logic [1:0] fvalid_r, held_r, hbef_r;
  logic signed [31:0] rpos_r [3];
  logic signed [31:0] rrot_r [3];
  logic moving_r;
  logic signed [31:0] height_r;
  logic [16:0] alpha_r, mscale_r;
  logic men_r;

  logic signed [31:0] raw_r  [3];
  logic signed [31:0] tpos_r [3];
  logic signed [31:0] trot_r [3];
  logic tvalid_r;

  logic arm_r;
  logic [1:0] ax_r, sub_r;
  logic [16:0] wa_r, scale_r;
  logic [15:0] quo_r;
  logic signed [31:0] tgt_r [3];
  logic [1:0] cmd_r;
  logic zero_r;

  logic out_valid_r;
  logic [1:0] out_cmd_r;
  logic signed [31:0] out_tgt_r [3];
  logic signed [31:0] out_rot_r [3];
  logic [16:0] out_scale_r;

  gdbs_pkg::mac_ctl_t mac_ctl;
  logic signed [32:0] mac_a;
  logic signed [17:0] mac_b;
  logic signed [51:0] mac_acc;
  logic signed [35:0] acc_rnd;

  logic div_ge;
  logic in_take, out_free, in_box;

  gdbs_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (mac_acc)
  );

  assign acc_rnd = gdbs_pkg::rnd_q16(mac_acc);
  // The remainder left by the quotient estimate is below twice the span.
  assign div_ge  = mac_acc[19:0] >= {1'b0, gdbs_pkg::H_SPAN};

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign in_box = (tgt_r[0] >= gdbs_pkg::WS_X_MIN) && (tgt_r[0] <= gdbs_pkg::WS_X_MAX) &&
                  (tgt_r[1] >= gdbs_pkg::WS_Y_MIN) && (tgt_r[1] <= gdbs_pkg::WS_Y_MAX) &&
                  (tgt_r[2] >= gdbs_pkg::WS_Z_MIN) && (tgt_r[2] <= gdbs_pkg::WS_Z_MAX);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.command       = out_cmd_r;
  assign out_ch.target_x      = out_tgt_r[0];
  assign out_ch.target_y      = out_tgt_r[1];
  assign out_ch.target_z      = out_tgt_r[2];
  assign out_ch.target_rx     = out_rot_r[0];
  assign out_ch.target_ry     = out_rot_r[1];
  assign out_ch.target_rz     = out_rot_r[2];
  assign out_ch.scale_applied = out_scale_r;

  // Operand selection for the shared multiply-accumulate unit.
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    case (state_r)
      S_FILT: begin
        mac_ctl.en  = (sub_r != 2'd2);
        mac_ctl.clr = (sub_r == 2'd0);
        if (sub_r == 2'd0) begin
          mac_a = 33'(filt_r[arm_r][ax_r]);
          mac_b = gdbs_pkg::FILT_OLD;
        end else begin
          mac_a = 33'(raw_r[ax_r]);
          mac_b = gdbs_pkg::FILT_NEW;
        end
      end
      S_RMUL: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = 1'b1;
        mac_a = 33'(height_r) - 33'(gdbs_pkg::H_LOW);
        mac_b = gdbs_pkg::RAMP_RECIP;
      end
      S_RDIV: begin
        mac_ctl.en  = (sub_r != 2'd2);
        mac_ctl.clr = (sub_r == 2'd0);
        if (sub_r == 2'd0) begin
          mac_a = 33'(height_r) - 33'(gdbs_pkg::H_LOW);
          mac_b = gdbs_pkg::RAMP_GAIN;
        end else begin
          mac_a = gdbs_pkg::H_SPAN_NEG;
          mac_b = $signed({2'b00, quo_r});
        end
      end
      S_ACC: begin
        mac_ctl.en  = (sub_r == 2'd0);
        mac_ctl.clr = 1'b1;
        mac_a = 33'(filt_r[arm_r][ax_r]) - 33'(anch_r[arm_r][ax_r]);
        mac_b = $signed({1'b0, scale_r});
      end
      S_BLEND: begin
        mac_ctl.en  = (sub_r != 2'd2);
        mac_ctl.clr = (sub_r == 2'd0);
        if (sub_r == 2'd0) begin
          mac_a = 33'(sum_r[0][ax_r]);
          mac_b = $signed({1'b0, wa_r});
        end else begin
          mac_a = 33'(sum_r[1][ax_r]);
          mac_b = $signed({1'b0, 17'(gdbs_pkg::ONE_Q16 - wa_r)});
        end
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fvalid_r    <= '0;
      held_r      <= '0;
      hbef_r      <= '0;
      moving_r    <= 1'b0;
      height_r    <= gdbs_pkg::H_HIGH;
      alpha_r     <= gdbs_pkg::ALPHA_RESET;
      men_r       <= 1'b0;
      mscale_r    <= gdbs_pkg::MAN_RESET;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          filt_r[a][i] <= '0;
          anch_r[a][i] <= '0;
          sum_r[a][i]  <= '0;
        end
      end
      for (int i = 0; i < 3; i++) begin
        rpos_r[i] <= '0;
        rrot_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          gdbs_pkg::CFG_ALPHA:      alpha_r  <= gdbs_pkg::clamp_q16(cfg_ch.data);
          gdbs_pkg::CFG_MAN_ENABLE: men_r    <= cfg_ch.data[0];
          gdbs_pkg::CFG_MAN_SCALE:  mscale_r <= gdbs_pkg::clamp_q16(cfg_ch.data);
          default: begin
          end
        endcase
      end

      if (out_valid_r && out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            case (in_ch.operation)
              gdbs_pkg::OP_EXPERT_POS, gdbs_pkg::OP_LEARNER_POS: begin
                arm_r <= in_ch.operation[0];
                if (fvalid_r[in_ch.operation[0]]) begin
                  raw_r[0] <= in_ch.hand_x;
                  raw_r[1] <= in_ch.hand_y;
                  raw_r[2] <= in_ch.hand_z;
                  ax_r     <= 2'd0;
                  sub_r    <= 2'd0;
                  state_r  <= S_FILT;
                end else begin
                  // First sample after a release loads the filter directly.
                  filt_r[in_ch.operation[0]][0] <= in_ch.hand_x;
                  filt_r[in_ch.operation[0]][1] <= in_ch.hand_y;
                  filt_r[in_ch.operation[0]][2] <= in_ch.hand_z;
                  fvalid_r[in_ch.operation[0]]  <= 1'b1;
                end
              end
              gdbs_pkg::OP_EXPERT_BTN, gdbs_pkg::OP_LEARNER_BTN: begin
                held_r[in_ch.operation[0]] <= in_ch.pressed;
                if (!in_ch.pressed) begin
                  fvalid_r[in_ch.operation[0]] <= 1'b0;
                end
              end
              gdbs_pkg::OP_TICK: begin
                tvalid_r  <= in_ch.tool_valid;
                tpos_r[0] <= in_ch.tool_x;
                tpos_r[1] <= in_ch.tool_y;
                tpos_r[2] <= in_ch.tool_z;
                trot_r[0] <= in_ch.tool_rx;
                trot_r[1] <= in_ch.tool_ry;
                trot_r[2] <= in_ch.tool_rz;
                state_r   <= S_TICK;
              end
              default: begin
              end
            endcase
          end
        end

        S_FILT: begin
          if (sub_r == 2'd2) begin
            filt_r[arm_r][ax_r] <= gdbs_pkg::sat32(40'(acc_rnd));
            sub_r <= 2'd0;
            if (ax_r == 2'd2) begin
              fvalid_r[arm_r] <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end else begin
            sub_r <= sub_r + 2'd1;
          end
        end

        S_TICK: begin
          if (held_r == 2'b00) begin
            hbef_r <= 2'b00;
            if (moving_r) begin
              moving_r <= 1'b0;
              cmd_r    <= gdbs_pkg::CMD_STOP_IDLE;
              zero_r   <= 1'b1;
              state_r  <= S_EMIT;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            if (held_r != hbef_r) begin
              // The held set changed: re-anchor to the measured pose if there is one.
              if (tvalid_r) begin
                for (int i = 0; i < 3; i++) begin
                  rpos_r[i] <= tpos_r[i];
                  rrot_r[i] <= trot_r[i];
                end
                for (int a = 0; a < 2; a++) begin
                  if (held_r[a]) begin
                    for (int i = 0; i < 3; i++) begin
                      anch_r[a][i] <= filt_r[a][i];
                      sum_r[a][i]  <= '0;
                    end
                  end
                end
              end
              hbef_r <= held_r;
            end
            if (held_r == 2'b11) wa_r <= alpha_r;
            else if (held_r[0]) wa_r <= gdbs_pkg::ONE_Q16;
            else wa_r <= '0;
            arm_r <= !held_r[0];
            ax_r  <= 2'd0;
            sub_r <= 2'd0;
            if (men_r) begin
              scale_r <= mscale_r;
              state_r <= S_ACC;
            end else if (height_r <= gdbs_pkg::H_LOW) begin
              scale_r <= gdbs_pkg::RAMP_MIN;
              state_r <= S_ACC;
            end else if (height_r >= gdbs_pkg::H_HIGH) begin
              scale_r <= gdbs_pkg::ONE_Q16;
              state_r <= S_ACC;
            end else begin
              state_r <= S_RMUL;
            end
          end
        end

        S_RMUL: begin
          state_r <= S_RDIV;
        end

        S_RDIV: begin
          // The reciprocal estimate is the ramp quotient or one below it; the
          // remainder against the span decides which.
          if (sub_r == 2'd0) begin
            quo_r <= mac_acc[34:19];
            sub_r <= 2'd1;
          end else if (sub_r == 2'd1) begin
            sub_r <= 2'd2;
          end else begin
            scale_r <= gdbs_pkg::RAMP_MIN + {1'b0, quo_r + 16'(div_ge)};
            sub_r   <= 2'd0;
            state_r <= S_ACC;
          end
        end

        S_ACC: begin
          if (sub_r == 2'd0) begin
            sub_r <= 2'd1;
          end else begin
            sum_r[arm_r][ax_r]  <= gdbs_pkg::sat32(40'(sum_r[arm_r][ax_r]) + 40'(acc_rnd));
            anch_r[arm_r][ax_r] <= filt_r[arm_r][ax_r];
            sub_r <= 2'd0;
            if (ax_r == 2'd2) begin
              ax_r <= 2'd0;
              if (!arm_r && held_r[1]) begin
                arm_r <= 1'b1;
              end else begin
                state_r <= S_BLEND;
              end
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end
        end

        S_BLEND: begin
          if (sub_r == 2'd2) begin
            tgt_r[ax_r] <= gdbs_pkg::sat32(40'(rpos_r[ax_r]) + 40'(acc_rnd));
            sub_r <= 2'd0;
            if (ax_r == 2'd2) begin
              state_r <= S_FIN;
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end else begin
            sub_r <= sub_r + 2'd1;
          end
        end

        S_FIN: begin
          height_r <= tgt_r[2];
          moving_r <= in_box;
          cmd_r    <= in_box ? gdbs_pkg::CMD_MOVE : gdbs_pkg::CMD_STOP_WS;
          zero_r   <= 1'b0;
          state_r  <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_cmd_r   <= cmd_r;
            out_scale_r <= zero_r ? 17'd0 : scale_r;
            for (int i = 0; i < 3; i++) begin
              out_tgt_r[i] <= zero_r ? 32'sd0 : tgt_r[i];
              out_rot_r[i] <= zero_r ? 32'sd0 : rrot_r[i];
            end
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/tb_gated_dual_blend_setpoint.sv =====
// Testbench of the gated dual-arm blended setpoint block: predicted results checked per transaction.
typedef struct {
  logic [1:0] command;
  logic signed [31:0] tx, ty, tz, rx, ry, rz;
  logic [16:0] scale;
} setpoint_t;

class setpoint_scoreboard;
  // Predictor state for each arm; index 0 is the expert, 1 the learner.
  logic signed [31:0] filt [2][3];
  bit filt_ok [2];
  logic signed [31:0] ref_pt [2][3];
  logic signed [31:0] acc [2][3];
  bit held [2];
  bit held_prev [2];
  logic signed [31:0] base_pos [3];
  logic signed [31:0] base_rot [3];
  bit moving;
  logic signed [31:0] height;
  logic [16:0] alpha;
  bit man_en;
  logic [16:0] man_scale;
  setpoint_t pending [$];
  int errors;
  int n_moves, n_idle_stops, n_ws_stops;

  function new();
    errors = 0;
    n_moves = 0;
    n_idle_stops = 0;
    n_ws_stops = 0;
    clear();
  endfunction

  function void clear();
    for (int a = 0; a < 2; a++) begin
      filt_ok[a] = 0;
      held[a] = 0;
      held_prev[a] = 0;
      for (int i = 0; i < 3; i++) begin
        filt[a][i] = 0;
        ref_pt[a][i] = 0;
        acc[a][i] = 0;
      end
    end
    for (int i = 0; i < 3; i++) begin
      base_pos[i] = 0;
      base_rot[i] = 0;
    end
    moving = 0;
    height = 661022;
    alpha = 52429;
    man_en = 0;
    man_scale = 6554;
  endfunction

  function longint round16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function void write_reg(logic [1:0] idx, logic [16:0] d);
    logic [16:0] c;
    c = (d > 17'd65536) ? 17'd65536 : d;
    if (idx == gdbs_pkg::CFG_ALPHA) alpha = c;
    else if (idx == gdbs_pkg::CFG_MAN_ENABLE) man_en = d[0];
    else if (idx == gdbs_pkg::CFG_MAN_SCALE) man_scale = c;
  endfunction

  function logic [16:0] height_scale();
    longint h;
    h = height;
    if (h <= 333867) return 17'd6554;
    if (h >= 661022) return 17'd65536;
    return 17'(6554 + (58982 * (h - 333867)) / 327155);
  endfunction

  function void note_event(logic [2:0] op, logic signed [31:0] hand [3], bit pr,
                           bit tv, logic signed [31:0] tp [3], logic signed [31:0] tr [3]);
    int a;
    setpoint_t r;
    longint w, mix;
    logic signed [31:0] tgt [3];
    logic [16:0] sc;
    case (op)
      gdbs_pkg::OP_EXPERT_POS, gdbs_pkg::OP_LEARNER_POS: begin
        a = (op == gdbs_pkg::OP_EXPERT_POS) ? 0 : 1;
        for (int i = 0; i < 3; i++)
          filt[a][i] = filt_ok[a] ? clip32(round16(55706 * longint'(filt[a][i]) +
                                                   9830 * longint'(hand[i]))) : hand[i];
        filt_ok[a] = 1;
      end
      gdbs_pkg::OP_EXPERT_BTN, gdbs_pkg::OP_LEARNER_BTN: begin
        a = (op == gdbs_pkg::OP_EXPERT_BTN) ? 0 : 1;
        held[a] = pr;
        if (!pr) filt_ok[a] = 0;
      end
      gdbs_pkg::OP_TICK: begin
        if (!held[0] && !held[1]) begin
          held_prev[0] = 0;
          held_prev[1] = 0;
          if (moving) begin
            moving = 0;
            r = '{gdbs_pkg::CMD_STOP_IDLE, 0, 0, 0, 0, 0, 0, 0};
            pending.push_back(r);
          end
        end else begin
          if (held[0] != held_prev[0] || held[1] != held_prev[1]) begin
            if (tv) begin
              for (int i = 0; i < 3; i++) begin
                base_pos[i] = tp[i];
                base_rot[i] = tr[i];
              end
              for (int k = 0; k < 2; k++)
                if (held[k])
                  for (int i = 0; i < 3; i++) begin
                    ref_pt[k][i] = filt[k][i];
                    acc[k][i] = 0;
                  end
            end
            held_prev[0] = held[0];
            held_prev[1] = held[1];
          end
          w = (held[0] && held[1]) ? alpha : (held[0] ? 65536 : 0);
          sc = man_en ? man_scale : height_scale();
          for (int k = 0; k < 2; k++)
            if (held[k])
              for (int i = 0; i < 3; i++) begin
                acc[k][i] = clip32(longint'(acc[k][i]) +
                  round16((longint'(filt[k][i]) - longint'(ref_pt[k][i])) * longint'(sc)));
                ref_pt[k][i] = filt[k][i];
              end
          for (int i = 0; i < 3; i++) begin
            mix = w * acc[0][i] + (65536 - w) * acc[1][i];
            tgt[i] = clip32(longint'(base_pos[i]) + round16(mix));
          end
          height = tgt[2];
          moving = tgt[0] >= -32'sd6375342 && tgt[0] <= 32'sd1677722 &&
                   tgt[1] >= -32'sd5872026 && tgt[1] <= 32'sd5872026 &&
                   tgt[2] >= -32'sd335544 && tgt[2] <= 32'sd6375342;
          r.command = moving ? gdbs_pkg::CMD_MOVE : gdbs_pkg::CMD_STOP_WS;
          r.tx = tgt[0];
          r.ty = tgt[1];
          r.tz = tgt[2];
          r.rx = base_rot[0];
          r.ry = base_rot[1];
          r.rz = base_rot[2];
          r.scale = sc;
          pending.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function void cmp(string name, longint e, longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  function void check_result(setpoint_t got);
    setpoint_t e;
    if (pending.size() == 0) begin
      $error("unexpected result transaction, command %0d", got.command);
      errors++;
      return;
    end
    e = pending.pop_front();
    cmp("command", e.command, got.command);
    cmp("target_x", e.tx, got.tx);
    cmp("target_y", e.ty, got.ty);
    cmp("target_z", e.tz, got.tz);
    cmp("target_rx", e.rx, got.rx);
    cmp("target_ry", e.ry, got.ry);
    cmp("target_rz", e.rz, got.rz);
    cmp("scale_applied", e.scale, got.scale);
    if (got.command == gdbs_pkg::CMD_MOVE) n_moves++;
    else if (got.command == gdbs_pkg::CMD_STOP_IDLE) n_idle_stops++;
    else n_ws_stops++;
  endfunction
endclass

module tb_gated_dual_blend_setpoint;

  logic clk;
  logic rst_n;
  gdbs_in_if in_ch();
  gdbs_out_if out_ch();
  gdbs_cfg_if cfg_ch();

  gated_dual_blend_setpoint dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  setpoint_scoreboard board;
  int idle_cycles;
  int n_events;
  int n_cfg;
  bit sink_on;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Watchdog: nothing accepted on any channel for too long ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("watchdog expired with %0d results pending", board.pending.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stalls, check every accepted transaction.
  initial begin
    setpoint_t got;
    int gap;
    out_ch.ready = 0;
    wait (sink_on);
    forever begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!out_ch.valid);
      got.command = out_ch.command;
      got.tx = out_ch.target_x;
      got.ty = out_ch.target_y;
      got.tz = out_ch.target_z;
      got.rx = out_ch.target_rx;
      got.ry = out_ch.target_ry;
      got.rz = out_ch.target_rz;
      got.scale = out_ch.scale_applied;
      board.check_result(got);
    end
  end

  // Valid stays up after an accepted transaction so that the next one can
  // follow at once; a pause or a drain drops it.
  task automatic send_event(logic [2:0] op, logic signed [31:0] hx, logic signed [31:0] hy,
                            logic signed [31:0] hz, bit pr, bit tv,
                            logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz, logic signed [31:0] qx,
                            logic signed [31:0] qy, logic signed [31:0] qz, int gap);
    logic signed [31:0] hand [3];
    logic signed [31:0] tp [3];
    logic signed [31:0] tr [3];
    hand = '{hx, hy, hz};
    tp = '{px, py, pz};
    tr = '{qx, qy, qz};
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.operation <= op;
    in_ch.hand_x <= hx;
    in_ch.hand_y <= hy;
    in_ch.hand_z <= hz;
    in_ch.pressed <= pr;
    in_ch.tool_valid <= tv;
    in_ch.tool_x <= px;
    in_ch.tool_y <= py;
    in_ch.tool_z <= pz;
    in_ch.tool_rx <= qx;
    in_ch.tool_ry <= qy;
    in_ch.tool_rz <= qz;
    do @(posedge clk); while (!in_ch.ready);
    board.note_event(op, hand, pr, tv, tp, tr);
    n_events++;
  endtask

  function automatic logic signed [31:0] any32();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly values near the workspace so that targets land inside it.
  function automatic logic signed [31:0] near32();
    if ($urandom_range(0, 9) == 0) return any32();
    return $signed($urandom_range(0, 12000000)) - 32'sd6000000;
  endfunction

  task automatic hand_pos(logic [2:0] op, int gap);
    send_event(op, near32(), near32(), near32(), $urandom_range(0, 1), $urandom_range(0, 1),
               any32(), any32(), any32(), any32(), any32(), any32(), gap);
  endtask

  task automatic button(logic [2:0] op, bit pr, int gap);
    send_event(op, any32(), any32(), any32(), pr, $urandom_range(0, 1),
               any32(), any32(), any32(), any32(), any32(), any32(), gap);
  endtask

  task automatic tick(bit tv, int gap);
    logic signed [31:0] z;
    z = $signed($urandom_range(0, 800000));
    if ($urandom_range(0, 7) == 0) z = any32();
    send_event(gdbs_pkg::OP_TICK, any32(), any32(), any32(), $urandom_range(0, 1), tv,
               near32() / 4, near32() / 4, z, any32(), any32(), any32(), gap);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [16:0] d);
    @(posedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, d);
    n_cfg++;
    cfg_ch.valid <= 0;
  endtask

  // Lets the block drain fully before a register write.
  task automatic settle();
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic int rgap();
    return ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 5);
  endfunction

  initial begin
    logic [16:0] alphas [5];
    board = new();
    n_events = 0;
    n_cfg = 0;
    sink_on = 0;
    idle_cycles = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.operation = gdbs_pkg::OP_EXPERT_POS;
    in_ch.hand_x = 0;
    in_ch.hand_y = 0;
    in_ch.hand_z = 0;
    in_ch.pressed = 0;
    in_ch.tool_valid = 0;
    in_ch.tool_x = 0;
    in_ch.tool_y = 0;
    in_ch.tool_z = 0;
    in_ch.tool_rx = 0;
    in_ch.tool_ry = 0;
    in_ch.tool_rz = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = gdbs_pkg::CFG_ALPHA;
    cfg_ch.data = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    sink_on = 1;

    // Directed: tick with nobody holding, extreme hands, saturating filter,
    // re-anchor with and without a tool pose, every gating, unknown codes.
    tick(1, 0);
    send_event(gdbs_pkg::OP_EXPERT_POS, 32'sh7fffffff, 32'sh80000000, 0,
               0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_event(gdbs_pkg::OP_EXPERT_POS, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
               0, 0, 0, 0, 0, 0, 0, 0, 0);
    button(gdbs_pkg::OP_EXPERT_BTN, 1, 0);
    send_event(gdbs_pkg::OP_TICK, 0, 0, 0, 0, 1, 32'sh7fffffff, 32'sh80000000,
               32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, -1, 0);
    send_event(gdbs_pkg::OP_EXPERT_POS, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
               0, 0, 0, 0, 0, 0, 0, 0, 0);
    tick(1, 0);
    send_event(gdbs_pkg::OP_LEARNER_POS, 1000, -1000, 400000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    button(gdbs_pkg::OP_LEARNER_BTN, 1, 0);
    send_event(gdbs_pkg::OP_TICK, 0, 0, 0, 0, 1, 0, 0, 500000, 1, 2, 3, 0);
    hand_pos(gdbs_pkg::OP_LEARNER_POS, 0);
    tick(1, 0);
    button(gdbs_pkg::OP_EXPERT_BTN, 0, 0);
    tick(0, 0);
    tick(1, 0);
    button(gdbs_pkg::OP_LEARNER_BTN, 0, 0);
    tick(1, 0);
    tick(1, 0);
    for (int op = 5; op < 8; op++) hand_pos(3'(op), 0);

    alphas = '{17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd52429};
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      write_cfg(gdbs_pkg::CFG_ALPHA,
                (ph < 5) ? alphas[ph] : 17'($urandom_range(0, 131071)));
      write_cfg(gdbs_pkg::CFG_MAN_ENABLE,
                (ph % 3 == 1) ? 17'h1fffe | 17'(ph & 1) : 17'(ph % 2));
      write_cfg(gdbs_pkg::CFG_MAN_SCALE, (ph == 2) ? 17'd0 : (ph == 3) ? 17'd131071 :
                                         17'($urandom_range(0, 131071)));
      if (ph == 4) write_cfg(2'd3, 17'($urandom));
      if (ph == 6) begin
        // Hold off until every result has come, then resume.
        while (board.pending.size() != 0) @(posedge clk);
      end
      for (int s = 0; s < 86; s++) begin
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) begin
          button(gdbs_pkg::OP_EXPERT_BTN, $urandom_range(0, 1), rgap());
          button(gdbs_pkg::OP_LEARNER_BTN, $urandom_range(0, 1), rgap());
        end else if (k == 1) begin
          hand_pos(3'($urandom_range(0, 7)), rgap());
        end else begin
          // Well-formed control cycle: positions then a tick.
          if ($urandom_range(0, 2) != 0) hand_pos(gdbs_pkg::OP_EXPERT_POS, rgap());
          if ($urandom_range(0, 2) != 0) hand_pos(gdbs_pkg::OP_LEARNER_POS, rgap());
          tick($urandom_range(0, 5) != 0, rgap());
        end
      end
    end

    settle();
    repeat (100) @(posedge clk);
    $display("Ran %0d events and %0d register writes; results: %0d moves, %0d idle stops,",
             n_events, n_cfg, board.n_moves, board.n_idle_stops);
    $display("%0d workspace stops.", board.n_ws_stops);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
